[sv/fccw_pkg.sv]
// Shared types and constants for the FAT12 cluster chain walker.
// Used by fccw_ctrl, fccw_dpath and the top level fat12_cluster_chain_walker.
`default_nettype none

package fccw_pkg;

	// Default table geometry
	localparam int TABLE_ENTRIES_DEFAULT       = 4096;
	localparam int SECTORS_PER_CLUSTER_DEFAULT = 8;

	// Register reset values
	localparam logic [15:0] DATA_START_RST = 16'd32;
	localparam logic [11:0] END_THR_RST    = 12'hFF8;

	// Field widths
	localparam int ACTION_W   = 2;
	localparam int BYTE_IDX_W = 13;
	localparam int CLUSTER_W  = 12;
	localparam int SECTOR_W   = 17;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 32;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic REG_DATA_START = 1'b0;
	localparam logic REG_END_THR    = 1'b1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_START = 2'd1,
		ACT_CONT  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Controller to datapath
	typedef struct packed {
		logic wr_byte;     // write one table byte from the input transaction
		logic load_start;  // load the current cluster from the input transaction
		logic rd_b;        // read the second table byte instead of the first
		logic cap_a;       // hold first byte, form the sector base
		logic cap_b;       // unpack the next cluster
		logic clr_sec;     // clear the sector counter
		logic emit;        // load a sector result into the output register
		logic emit_end;    // load a chain-end result into the output register
		logic commit;      // advance the current cluster
	} fccw_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic walk_ok;      // current cluster is nonzero and below the threshold
		logic out_free;     // output register can take a result this cycle
		logic last_sector;  // sector counter is on the last sector of the cluster
	} fccw_stat_t;

endpackage

`default_nettype wire

[sv/fccw_ctrl.sv]
// Controller state machine for the FAT12 cluster chain walker.
// Depends on fccw_pkg; drives fccw_dpath through fccw_cmd_t.
`default_nettype none

module fccw_ctrl
	import fccw_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [ACTION_W-1:0] in_action,
	output logic                     in_ready,
	input  wire fccw_stat_t          stat,
	output fccw_cmd_t                cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOOK = 5'b00010,
		ST_RD1  = 5'b00100,
		ST_RD2  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	action_t act;

	assign act      = action_t'(in_action);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (act)
						ACT_WRITE: cmd.wr_byte = 1'b1;
						ACT_START: begin
							cmd.load_start = 1'b1;
							state_d        = ST_LOOK;
						end
						ACT_CONT: state_d = ST_LOOK;
						ACT_NONE: state_d = ST_IDLE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOK: begin
				// first table byte is read here
				cmd.clr_sec = 1'b1;
				if (stat.walk_ok) begin
					state_d = ST_RD1;
				end else if (stat.out_free) begin
					cmd.emit_end = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_RD1: begin
				cmd.rd_b  = 1'b1;
				cmd.cap_a = 1'b1;
				state_d   = ST_RD2;
			end
			ST_RD2: begin
				cmd.cap_b = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.last_sector) begin
						cmd.commit = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[sv/fccw_dpath.sv]
// Datapath of the FAT12 cluster chain walker: table memory, registers,
// entry unpacking, sector arithmetic and output register. Depends on fccw_pkg.
`default_nettype none

module fccw_dpath
	import fccw_pkg::*;
#(
	parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEFAULT,
	parameter int SECTORS_PER_CLUSTER = SECTORS_PER_CLUSTER_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [S_TDATA_W-1:0]  in_data,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire fccw_cmd_t             cmd,
	output fccw_stat_t                 stat,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [M_TDATA_W-1:0]       out_data,
	output logic                       out_last,
	output logic                       out_end
);

	localparam int TBYTES = (TABLE_ENTRIES / 2) * 3;
	localparam int ABITS  = $clog2(TBYTES);
	localparam int CW     = (SECTORS_PER_CLUSTER > 1) ? $clog2(SECTORS_PER_CLUSTER) : 1;
	localparam logic [SECTOR_W-1:0]   SPC    = SECTOR_W'(SECTORS_PER_CLUSTER);
	localparam logic [CW-1:0]         SEC_LAST = CW'(SECTORS_PER_CLUSTER - 1);
	localparam logic [BYTE_IDX_W-1:0] TB_LIM = BYTE_IDX_W'(TBYTES);
	localparam logic [BYTE_IDX_W-1:0] TE_LIM = BYTE_IDX_W'(TABLE_ENTRIES);

	logic [BYTE_IDX_W-1:0] in_idx;
	logic [7:0]            in_byte;
	logic [CLUSTER_W-1:0]  in_start;

	assign in_idx   = in_data[12:0];
	assign in_byte  = in_data[20:13];
	assign in_start = in_data[32:21];

	// Configuration registers
	logic [CFG_DATA_W-1:0] ds_q;
	logic [CLUSTER_W-1:0]  thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_q  <= DATA_START_RST;
			thr_q <= END_THR_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_DATA_START) begin
				ds_q <= cfg_data;
			end else begin
				thr_q <= cfg_data[CLUSTER_W-1:0];
			end
		end
	end

	// Current cluster
	logic [CLUSTER_W-1:0] cur_q;
	logic [CLUSTER_W-1:0] next_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (cmd.load_start) begin
			cur_q <= in_start;
		end else if (cmd.commit) begin
			cur_q <= next_q;
		end
	end

	assign stat.walk_ok = (cur_q != '0) && (cur_q < thr_q);

	// Table memory, one port each way
	logic [7:0]            mem [TBYTES];
	logic [7:0]            rd_q;
	logic [BYTE_IDX_W-1:0] ent_base;
	logic [BYTE_IDX_W-1:0] addr_a;
	logic [BYTE_IDX_W-1:0] rd_addr;
	logic                  in_tbl;

	assign ent_base = BYTE_IDX_W'({cur_q[CLUSTER_W-1:1], 1'b0})
		+ BYTE_IDX_W'(cur_q[CLUSTER_W-1:1]);
	assign addr_a   = ent_base + BYTE_IDX_W'(cur_q[0]);
	assign rd_addr  = cmd.rd_b ? (addr_a + 1'b1) : addr_a;
	assign in_tbl   = BYTE_IDX_W'(cur_q) < TE_LIM;

	always_ff @(posedge clk) begin
		if (cmd.wr_byte && (in_idx < TB_LIM)) begin
			mem[in_idx[ABITS-1:0]] <= in_byte;
		end
		rd_q <= mem[rd_addr[ABITS-1:0]];
	end

	// Entry unpacking and sector base
	logic [7:0]          byte_a_q;
	logic [SECTOR_W-1:0] sec_base_q;
	logic [CLUSTER_W-1:0] next_d;

	always_comb begin
		if (!in_tbl) begin
			next_d = '0;
		end else if (cur_q[0]) begin
			next_d = {rd_q, byte_a_q[7:4]};
		end else begin
			next_d = {rd_q[3:0], byte_a_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			byte_a_q   <= rd_q;
			sec_base_q <= SECTOR_W'(cur_q) * SPC + SECTOR_W'(ds_q);
		end
		if (cmd.cap_b) begin
			next_q <= next_d;
		end
	end

	// Sector counter
	logic [CW-1:0] sec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= '0;
		end else if (cmd.clr_sec) begin
			sec_q <= '0;
		end else if (cmd.emit) begin
			sec_q <= sec_q + 1'b1;
		end
	end

	assign stat.last_sector = (sec_q == SEC_LAST);

	// Output register
	logic                 oval_q;
	logic [SECTOR_W-1:0]  osec_q;
	logic [CLUSTER_W-1:0] onext_q;
	logic                 olast_q;
	logic                 oend_q;
	logic                 next_ok;

	assign next_ok       = (next_q != '0) && (next_q < thr_q);
	assign stat.out_free = !oval_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_end) begin
			oval_q <= 1'b1;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_end) begin
			osec_q  <= '0;
			onext_q <= '0;
			olast_q <= 1'b1;
			oend_q  <= 1'b1;
		end else if (cmd.emit) begin
			osec_q  <= sec_base_q + SECTOR_W'(sec_q);
			onext_q <= stat.last_sector ? next_q : '0;
			olast_q <= stat.last_sector;
			oend_q  <= stat.last_sector && !next_ok;
		end
	end

	assign out_valid = oval_q;
	assign out_data  = {3'b000, onext_q, osec_q};
	assign out_last  = olast_q;
	assign out_end   = oend_q;

endmodule

`default_nettype wire

[sv/fat12_cluster_chain_walker.sv]
// Top level of the FAT12 cluster chain walker.
// Depends on fccw_pkg; instantiates fccw_ctrl and fccw_dpath.
//
// Usage:
//   The input stream carries one item per transaction. s_axis_tuser holds
//   the action: write a table byte, start a chain at a given cluster, or
//   continue the chain from the stored cluster. Table writes complete in
//   the cycle they are taken and produce no result.
//   A walk of a valid cluster sends SECTORS_PER_CLUSTER sector addresses on
//   the output stream, one per cycle while the output does not stall; the
//   last one has tlast set and carries the next cluster, with tuser set
//   when that cluster ends the chain. An invalid cluster gives one result
//   with tlast and tuser set.
//   Steps of a walk: after the accepting cycle the block checks the cluster
//   and reads the first table byte, reads the second byte through the
//   single memory read port, unpacks the entry, then emits one sector per
//   cycle while the output is not stalled. An invalid cluster gives its
//   result from the checking state once the output register is free.
//   The output register lets a new item be taken while the last result of
//   the previous one still waits. The walk holds while the output register
//   is full and m_axis_tready is low; s_axis_tready is low until it is done.
//   Reset clears the current cluster to zero and loads data_start_sector
//   with 32 and end_threshold with 0xFF8. Table contents are undefined until
//   written. Configuration writes are always accepted and must come while
//   the block is idle.
`default_nettype none

module fat12_cluster_chain_walker
	import fccw_pkg::*;
#(
	parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEFAULT,
	parameter int SECTORS_PER_CLUSTER = SECTORS_PER_CLUSTER_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input stream
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [12:0] table_byte_index, [20:13] table_byte_value, [32:21] start_cluster
	input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] action
	input  wire logic [ACTION_W-1:0]   s_axis_tuser,
	// output stream
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [16:0] sector_address, [28:17] next_cluster
	output logic [M_TDATA_W-1:0]       m_axis_tdata,
	output logic                       m_axis_tlast,
	// [0] chain_end
	output logic                       m_axis_tuser,
	// configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	fccw_cmd_t  cmd;
	fccw_stat_t stat;

	// Registers take a write in any cycle
	assign cfg_ready = 1'b1;

	fccw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fccw_dpath #(
		.TABLE_ENTRIES       (TABLE_ENTRIES),
		.SECTORS_PER_CLUSTER (SECTORS_PER_CLUSTER)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_end   (m_axis_tuser)
	);

endmodule

`default_nettype wire
